[hw/rtl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int MAX_COLS    = 128;
	localparam int MAX_ROWS    = 32;
	localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(STORE_CELLS);
	localparam int CELL_W      = 16;
	localparam int COL_W       = 7;
	localparam int ROW_W       = 5;
	localparam int WREG_W      = 8;
	localparam int HREG_W      = 6;
	localparam int CODE_W      = 8;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
	localparam logic [7:0]        TEXT_ATTR    = 8'h07;
	localparam logic [7:0]        NEWLINE_CODE = 8'h0A;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_BACK  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} tcw_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} tcw_reg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_COPY,
		ST_BLANK,
		ST_DONE
	} tcw_state_t;

	typedef struct packed {
		logic [WREG_W-1:0] w;
		logic [HREG_W-1:0] h;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] last;
	} tcw_geom_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [7:0]       rchar;
		logic [7:0]       rattr;
		logic             scrolled;
	} tcw_res_t;

endpackage

[hw/rtl/tcw_if.sv]
`timescale 1ns / 1ps

interface tcw_cmd_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CODE_W-1:0] char_code;
	logic [ADDR_W-1:0] cell_index;

	modport source (output valid, cmd, char_code, cell_index, input ready);
	modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] cursor_col;
	logic [ROW_W-1:0] cursor_row;
	logic [7:0]       read_char;
	logic [7:0]       read_attr;
	logic             scrolled;

	modport source (output valid, cursor_col, cursor_row, read_char, read_attr, scrolled,
		input ready);
	modport sink   (input valid, cursor_col, cursor_row, read_char, read_attr, scrolled,
		output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/text_console_writer_top.sv]
`timescale 1ns / 1ps
// Put char, move back and read cell pass through the DONE state and the registered result stage
// before their result is shown; a new command is taken only in the idle state.
// A scroll first copies each row below the top one up by one row, reading the store through
// its registered read port, then blanks the bottom row.
// Clear blanks the screen area, one cell written per cycle through the single write port.
// Reset: cursor homed, 80x25 geometry, then a sweep blanks all 4096 cells of the store;
// no command is taken during the sweep, configuration writes are.
module text_console_writer_top import tcw_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	tcw_cmd_if.sink     cmd_ch,
	tcw_res_if.source   res_ch,
	tcw_cfg_if.sink     cfg_ch
);

	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	tcw_geom_t         geom;
	logic [WREG_W-1:0] w_eff;
	logic [HREG_W-1:0] h_eff;
	logic [13:0]       area;

	logic              done_valid;
	logic              take;
	tcw_res_t          res;
	logic              out_valid_q;
	tcw_res_t          out_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WREG_W'(80);
			height_q <= HREG_W'(25);
		end else if (cfg_ch.valid) begin
			unique case (tcw_reg_t'(cfg_ch.index))
				REG_WIDTH:  width_q  <= cfg_ch.data[WREG_W-1:0];
				REG_HEIGHT: height_q <= cfg_ch.data[HREG_W-1:0];
			endcase
		end
	end

	always_comb begin
		w_eff = width_q;
		if (width_q == '0) w_eff = WREG_W'(1);
		else if (width_q > WREG_W'(MAX_COLS)) w_eff = WREG_W'(MAX_COLS);
		h_eff = height_q;
		if (height_q == '0) h_eff = HREG_W'(1);
		else if (height_q > HREG_W'(MAX_ROWS)) h_eff = HREG_W'(MAX_ROWS);
	end

	assign area      = 14'(w_eff * h_eff);
	assign geom.w    = w_eff;
	assign geom.h    = h_eff;
	assign geom.base = ADDR_W'(14'(w_eff * (h_eff - 1'b1)));
	assign geom.last = ADDR_W'(area - 1'b1);

	assign take = done_valid && (!out_valid_q || res_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign res_ch.valid      = out_valid_q;
	assign res_ch.cursor_col = out_q.col;
	assign res_ch.cursor_row = out_q.row;
	assign res_ch.read_char  = out_q.rchar;
	assign res_ch.read_attr  = out_q.rattr;
	assign res_ch.scrolled   = out_q.scrolled;

	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.cmd_valid  (cmd_ch.valid),
		.cmd_ready  (cmd_ch.ready),
		.cmd        (cmd_ch.cmd),
		.char_code  (cmd_ch.char_code),
		.cell_index (cmd_ch.cell_index),
		.done_valid (done_valid),
		.take       (take),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (STORE_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[hw/rtl/tcw_ram.sv]
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/tcw_ctrl.sv]
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_geom_t         geom,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [CODE_W-1:0] char_code,
	input  logic [ADDR_W-1:0] cell_index,
	output logic              done_valid,
	input  logic              take,
	output tcw_res_t          res,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [ADDR_W-1:0] mem_raddr,
	input  logic [CELL_W-1:0] mem_rdata
);

	tcw_state_t        st_q, st_d;
	logic [ADDR_W-1:0] ptr_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	tcw_cmd_t          cmd_q;
	logic              scr_q;
	logic              copy_v_s1;
	logic [ADDR_W-1:0] copy_addr_s1;

	logic              accept;
	logic              issue;
	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W:0]    row_n;
	logic              need_scroll;
	logic [ROW_W-1:0]  row_last;
	logic [ADDR_W:0]   row_base;
	logic [ADDR_W-1:0] cur_addr;

	assign accept = cmd_valid && cmd_ready;
	assign issue  = (ptr_q != geom.base);

	assign row_base = (ADDR_W+1)'(row_q * geom.w);
	assign cur_addr = ADDR_W'(row_base + {{(ADDR_W+1-COL_W){1'b0}}, col_q});
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign row_last = ROW_W'(geom.h - 1'b1);

	always_comb begin
		col_n = col_q;
		row_n = {1'b0, row_q};
		if (char_code == NEWLINE_CODE) begin
			col_n = '0;
			row_n = row_inc;
		end else if (col_inc >= geom.w) begin
			col_n = '0;
			row_n = row_inc;
		end else begin
			col_n = col_inc[COL_W-1:0];
		end
	end

	assign need_scroll = (row_n >= geom.h);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_INIT:  if (ptr_q == {ADDR_W{1'b1}}) st_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					unique case (tcw_cmd_t'(cmd))
						CMD_PUT:   st_d = need_scroll ? ST_COPY : ST_DONE;
						CMD_CLEAR: st_d = ST_BLANK;
						CMD_BACK,
						CMD_READ:  st_d = ST_DONE;
					endcase
				end
			end
			ST_COPY:  if (!issue && !copy_v_s1) st_d = ST_BLANK;
			ST_BLANK: if (ptr_q == geom.last) st_d = ST_DONE;
			ST_DONE:  if (take) st_d = ST_IDLE;
			default:  st_d = ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready  = 1'b0;
		done_valid = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = ptr_q;
		mem_wdata  = BLANK_CELL;
		mem_re     = 1'b0;
		mem_raddr  = cell_index;
		unique case (st_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				mem_we    = accept && (tcw_cmd_t'(cmd) == CMD_PUT) &&
					(char_code != NEWLINE_CODE);
				mem_waddr = cur_addr;
				mem_wdata = {TEXT_ATTR, char_code};
				mem_re    = accept && (tcw_cmd_t'(cmd) == CMD_READ);
			end
			ST_COPY: begin
				mem_re    = issue;
				mem_raddr = ptr_q + ADDR_W'(geom.w);
				mem_we    = copy_v_s1;
				mem_waddr = copy_addr_s1;
				mem_wdata = mem_rdata;
			end
			ST_BLANK: begin
				mem_we = 1'b1;
			end
			ST_DONE: begin
				done_valid = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.col      = col_q;
		res.row      = row_q;
		res.scrolled = scr_q;
		res.rchar    = (cmd_q == CMD_READ) ? mem_rdata[7:0]  : 8'h00;
		res.rattr    = (cmd_q == CMD_READ) ? mem_rdata[15:8] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_INIT;
			ptr_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			cmd_q        <= CMD_PUT;
			scr_q        <= 1'b0;
			copy_v_s1    <= 1'b0;
			copy_addr_s1 <= '0;
		end else begin
			st_q      <= st_d;
			copy_v_s1 <= (st_q == ST_COPY) && issue;
			unique case (st_q)
				ST_INIT:  ptr_q <= ptr_q + 1'b1;
				ST_IDLE: begin
					ptr_q <= '0;
					if (accept) begin
						cmd_q <= tcw_cmd_t'(cmd);
						scr_q <= (tcw_cmd_t'(cmd) == CMD_PUT) && need_scroll;
						unique case (tcw_cmd_t'(cmd))
							CMD_PUT: begin
								col_q <= col_n;
								if (need_scroll) begin
									row_q <= row_last;
								end else begin
									row_q <= row_n[ROW_W-1:0];
								end
							end
							CMD_BACK: if (col_q != '0) col_q <= col_q - 1'b1;
							CMD_CLEAR: begin
								col_q <= '0;
								row_q <= '0;
							end
							CMD_READ: ;
						endcase
					end
				end
				ST_COPY: begin
					copy_addr_s1 <= ptr_q;
					if (issue) ptr_q <= ptr_q + 1'b1;
				end
				ST_BLANK: ptr_q <= ptr_q + 1'b1;
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_s1 |-> (copy_addr_s1 < ptr_q))
		else $error("copy write not behind read");

	a_blank_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_BLANK) |-> (ptr_q <= geom.last))
		else $error("blank pointer past screen area");

	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && mem_we) |-> accept)
		else $error("store written without a transfer");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && take) |=> (st_q == ST_IDLE))
		else $error("result taken but engine not idle");

	a_copy_to_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COPY && st_d == ST_BLANK) |-> (ptr_q == geom.base))
		else $error("scroll copy ended early");

endmodule

[verif/text_console_writer_top_test.sv]
`timescale 1ns / 1ps

module text_console_writer_top_test;
	import tcw_pkg::*;

	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int RANDOM_ITEMS = 1750;
	localparam int SETTLE_WAIT  = 8;
	localparam int MAX_REPORTS  = 40;

	typedef struct packed {
		logic              is_cfg;
		tcw_reg_t          reg_sel;
		logic [7:0]        reg_val;
		tcw_cmd_t          op;
		logic [CODE_W-1:0] code;
		logic [ADDR_W-1:0] idx;
		logic              typed;
		tcw_res_t          want;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 31;

	// typed rows carry their result, the others go through the screen predictor
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{0, REG_WIDTH,  8'h00, CMD_READ,  8'h00, 12'd0,   1, '{0, 0, 8'h20, 8'h07, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_READ,  8'h00, 12'hFFF, 1, '{0, 0, 8'h20, 8'h07, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_BACK,  8'h00, 12'd0,   1, '{0, 0, 8'h00, 8'h00, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'hFF, 12'd0,   1, '{1, 0, 8'h00, 8'h00, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h00, 12'hFFF, 1, '{2, 0, 8'h00, 8'h00, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_BACK,  8'h00, 12'd0,   1, '{1, 0, 8'h00, 8'h00, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_READ,  8'h00, 12'd0,   1, '{1, 0, 8'hFF, 8'h07, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h0A, 12'd0,   1, '{0, 1, 8'h00, 8'h00, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h41, 12'd0,   1, '{1, 1, 8'h00, 8'h00, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h42, 12'd0,   1, '{2, 1, 8'h00, 8'h00, 0}},
		// zero geometry acts as 1x1 with the cursor left outside it
		'{1, REG_WIDTH,  8'h00, CMD_PUT,   8'h00, 12'd0,   0, '0},
		'{1, REG_HEIGHT, 8'h00, CMD_PUT,   8'h00, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h43, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h0A, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_READ,  8'h00, 12'd3,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_CLEAR, 8'h00, 12'd0,   0, '0},
		'{1, REG_WIDTH,  8'h03, CMD_PUT,   8'h00, 12'd0,   0, '0},
		'{1, REG_HEIGHT, 8'h02, CMD_PUT,   8'h00, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h61, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h62, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h63, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h64, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h65, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h66, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_READ,  8'h00, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_BACK,  8'h00, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_CLEAR, 8'h00, 12'd0,   0, '0},
		// oversize registers clamp to the full store
		'{1, REG_WIDTH,  8'hFF, CMD_PUT,   8'h00, 12'd0,   0, '0},
		'{1, REG_HEIGHT, 8'hFF, CMD_PUT,   8'h00, 12'd0,   0, '0},
		'{0, REG_WIDTH,  8'h00, CMD_READ,  8'h00, 12'hFFF, 1, '{0, 0, 8'h20, 8'h07, 0}},
		'{0, REG_WIDTH,  8'h00, CMD_PUT,   8'h0A, 12'd0,   0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	tcw_cmd_if cmd_ch ();
	tcw_res_if res_ch ();
	tcw_cfg_if cfg_ch ();

	text_console_writer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch),
		.cfg_ch (cfg_ch)
	);

	// screen predictor state
	logic [CELL_W-1:0] screen_copy [STORE_CELLS];
	int unsigned       cur_col, cur_row;
	int unsigned       scr_w, scr_h;

	tcw_res_t pending_results [$];

	int cycle_count, error_count;
	int send_idle_pct, recv_stall_pct;
	int n_items, n_scrolls, n_clears, n_reads, n_phases, n_reg_writes;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d with %0d results outstanding", cycle_count,
				pending_results.size());
			$display("text_console_writer_top_test: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < MAX_REPORTS)
			$display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want,
				cycle_count);
		error_count++;
	endtask

	function automatic void console_step(input tcw_cmd_t op, input logic [CODE_W-1:0] code,
		input logic [ADDR_W-1:0] idx, output tcw_res_t res);
		int unsigned addr, x, y;
		res = '0;
		case (op)
			CMD_PUT: begin
				if (code == NEWLINE_CODE) begin
					cur_col = 0;
					cur_row++;
				end else begin
					addr = cur_row * scr_w + cur_col;
					if (addr < STORE_CELLS)
						screen_copy[addr] = {TEXT_ATTR, code};
					cur_col++;
					if (cur_col >= scr_w) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= scr_h) begin
					for (y = 1; y < scr_h; y++)
						for (x = 0; x < scr_w; x++)
							screen_copy[(y - 1) * scr_w + x] = screen_copy[y * scr_w + x];
					for (x = 0; x < scr_w; x++)
						screen_copy[(scr_h - 1) * scr_w + x] = BLANK_CELL;
					cur_row = scr_h - 1;
					res.scrolled = 1'b1;
				end
			end
			CMD_BACK: begin
				if (cur_col > 0)
					cur_col--;
			end
			CMD_CLEAR: begin
				for (addr = 0; addr < scr_w * scr_h; addr++)
					screen_copy[addr] = BLANK_CELL;
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
				if (idx < STORE_CELLS) begin
					res.rchar = screen_copy[idx][7:0];
					res.rattr = screen_copy[idx][15:8];
				end
			end
		endcase
		res.col = cur_col[COL_W-1:0];
		res.row = cur_row[ROW_W-1:0];
	endfunction

	task automatic send_command(input tcw_cmd_t op, input logic [CODE_W-1:0] code,
		input logic [ADDR_W-1:0] idx, input logic typed, input tcw_res_t want);
		tcw_res_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      = 1'b1;
		cmd_ch.cmd        = op;
		cmd_ch.char_code  = code;
		cmd_ch.cell_index = idx;
		do @(posedge clk); while (!cmd_ch.ready);
		console_step(op, code, idx, predicted);
		pending_results.push_back(typed ? want : predicted);
		n_items++;
		n_scrolls += predicted.scrolled;
		n_clears  += (op == CMD_CLEAR);
		n_reads   += (op == CMD_READ);
	endtask

	// drop valid and let the block drain before touching the registers
	task automatic settle();
		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_register(input tcw_reg_t sel, input logic [7:0] val);
		logic [HREG_W-1:0] hv;
		settle();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = sel;
		cfg_ch.data  = val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		hv = val[HREG_W-1:0];
		if (sel == REG_WIDTH)
			scr_w = (val == 0) ? 1 : ((val > MAX_COLS) ? MAX_COLS : val);
		else
			scr_h = (hv == 0) ? 1 : ((hv > MAX_ROWS) ? MAX_ROWS : hv);
		n_reg_writes++;
	endtask

	always @(posedge clk) begin : result_check
		tcw_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("transfer with nothing pending", res_ch.cursor_col, 0);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.cursor_col !== want.col)
					report_mismatch("cursor_col", res_ch.cursor_col, want.col);
				if (res_ch.cursor_row !== want.row)
					report_mismatch("cursor_row", res_ch.cursor_row, want.row);
				if (res_ch.read_char !== want.rchar)
					report_mismatch("read_char", res_ch.read_char, want.rchar);
				if (res_ch.read_attr !== want.rattr)
					report_mismatch("read_attr", res_ch.read_attr, want.rattr);
				if (res_ch.scrolled !== want.scrolled)
					report_mismatch("scrolled", res_ch.scrolled, want.scrolled);
			end
		end
	end

	initial begin
		int unsigned      pick, n_phase_items, random_sent;
		logic [7:0]       w_val, h_val;
		tcw_cmd_t         op;
		logic [CODE_W-1:0] code;
		logic [ADDR_W-1:0] idx;

		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.cmd        = CMD_PUT;
		cmd_ch.char_code  = '0;
		cmd_ch.cell_index = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_WIDTH;
		cfg_ch.data       = '0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		for (int i = 0; i < STORE_CELLS; i++)
			screen_copy[i] = BLANK_CELL;
		cur_col = 0;
		cur_row = 0;
		scr_w   = 80;
		scr_h   = 25;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (DIRECTED[i].is_cfg)
				write_register(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
			else
				send_command(DIRECTED[i].op, DIRECTED[i].code, DIRECTED[i].idx,
					DIRECTED[i].typed, DIRECTED[i].want);
		end

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (n_phases % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// full store: slow scrolls and clears, so only a handful of commands
				case ($urandom_range(0, 2))
					0: w_val = 8'd128;
					1: w_val = 8'd255;
					default: w_val = 8'($urandom_range(129, 255));
				endcase
				case ($urandom_range(0, 2))
					0: h_val = 8'd32;
					1: h_val = 8'd63;
					default: h_val = {2'($urandom_range(0, 3)), 6'($urandom_range(32, 63))};
				endcase
				n_phase_items = 12;
			end else if (pick < 3) begin
				w_val = 8'($urandom_range(0, 255));
				h_val = {2'($urandom_range(0, 3)), 6'($urandom_range(0, 3))};
				n_phase_items = 40;
			end else begin
				w_val = 8'($urandom_range(0, 12));
				h_val = {2'($urandom_range(0, 3)), 6'($urandom_range(0, 6))};
				n_phase_items = 60;
			end
			if ($urandom_range(0, 1)) begin
				write_register(REG_WIDTH, w_val);
				write_register(REG_HEIGHT, h_val);
			end else begin
				write_register(REG_HEIGHT, h_val);
				write_register(REG_WIDTH, w_val);
			end

			for (int k = 0; k < n_phase_items; k++) begin
				pick = $urandom_range(0, 99);
				code = 8'($urandom_range(0, 255));
				idx  = 12'($urandom_range(0, STORE_CELLS - 1));
				if (pick < 55) begin
					op = CMD_PUT;
					if ($urandom_range(0, 6) == 0)
						code = NEWLINE_CODE;
				end else if (pick < 67) begin
					op = CMD_BACK;
				end else if (pick < 95) begin
					op = CMD_READ;
					if ($urandom_range(0, 3) != 0)
						idx = 12'($urandom_range(0, scr_w * scr_h - 1));
				end else begin
					op = CMD_CLEAR;
				end
				send_command(op, code, idx, 1'b0, '0);
				random_sent++;
			end
			n_phases++;
		end

		settle();

		$display("%0d commands over %0d screen geometries, %0d register writes",
			n_items, n_phases, n_reg_writes);
		$display("%0d scrolls, %0d clears and %0d cell reads predicted", n_scrolls, n_clears,
			n_reads);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("text_console_writer_top_test: clean");
		end else begin
			$display("%0d mismatches", error_count);
			$display("text_console_writer_top_test: errors");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer_top.sv
verif/text_console_writer_top_test.sv
